@@ hw/rtl/rflc_pkg.sv @@
// types and constants shared by the relay lockout controller
package rflc_pkg;

   localparam int unsigned NUM_CH = 3;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_SET   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OFF    = 2'd0,
      ST_ON     = 2'd1,
      ST_LOCKED = 2'd2
   } status_type;

   localparam logic [1:0] CH_FAN  = 2'd0;
   localparam logic [1:0] CH_HEAT = 2'd1;
   localparam logic [1:0] CH_COOL = 2'd2;

   localparam logic [1:0] REG_TIMEOUT     = 2'd0;
   localparam logic [1:0] REG_LOCKOUT     = 2'd1;
   localparam logic [1:0] REG_FAN_LOCKOUT = 2'd2;

   localparam logic [7:0]  TIMEOUT_RST     = 8'd120;
   localparam logic [15:0] LOCKOUT_RST     = 16'd300;
   localparam logic [15:0] FAN_LOCKOUT_RST = 16'd60;

   typedef logic [7:0]  wdog_type;
   typedef logic [15:0] lock_type;

endpackage

@@ hw/rtl/relay_failsafe_lockout_controller.sv @@
// relay lockout controller: fan, heat and cool relays with lockout and watchdog counters
// an accepted request item is registered in the input stage, then its result item in the result stage
// throughput: one item per cycle while the result side does not stall, set by the state update stage
// the request side stalls only while a held result is stalled and the input stage is full
// reset (synchronous): relays off, watchdogs zero, lockouts and registers at their defaults
module relay_failsafe_lockout_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_channel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_relay_bits,
   output logic [1:0]  rsp_channel_status,
   output logic        rsp_accepted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rflc_pkg::*;

   // configuration
   wdog_type timeout_ff;
   lock_type lockout_ff;
   lock_type fan_lockout_ff;

   // input stage
   logic       s1_valid_ff;
   action_type s1_action_ff;
   logic [1:0] s1_channel_ff;

   // relay state
   logic [NUM_CH-1:0] relay_ff, relay_in;
   wdog_type          wdog_ff [NUM_CH];
   wdog_type          wdog_in [NUM_CH];
   lock_type          lock_ff [NUM_CH];
   lock_type          lock_in [NUM_CH];

   // result stage
   logic       out_valid_ff;
   logic [2:0] out_relay_ff;
   status_type out_status_ff, out_status_in;
   logic       out_acc_ff, out_acc_in;

   logic out_free;
   logic advance;
   logic chan_ok;
   logic cool_on;
   logic heat_on;
   logic req_take;

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign chan_ok   = (s1_channel_ff != 2'd3);
   assign heat_on   = relay_ff[CH_HEAT] && (lock_ff[CH_HEAT] == '0);
   assign cool_on   = relay_ff[CH_COOL] && (lock_ff[CH_COOL] == '0);

   assign rsp_valid          = out_valid_ff;
   assign rsp_relay_bits     = out_relay_ff;
   assign rsp_channel_status = out_status_ff;
   assign rsp_accepted       = out_acc_ff;

   always_comb begin
      wdog_type wdec;
      relay_in   = relay_ff;
      wdog_in    = wdog_ff;
      lock_in    = lock_ff;
      out_acc_in = 1'b0;
      wdec       = '0;
      case (s1_action_ff)
         ACT_TICK: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (lock_ff[ch] != '0) begin
                  lock_in[ch] = lock_ff[ch] - 16'd1;
               end else if (relay_ff[ch]) begin
                  wdec = (wdog_ff[ch] != '0) ? wdog_ff[ch] - 8'd1 : '0;
                  if (wdec == '0) begin
                     // watchdog expired: switch off and lock
                     wdog_in[ch]  = '0;
                     relay_in[ch] = 1'b0;
                     lock_in[ch]  = (ch == 0) ? fan_lockout_ff : lockout_ff;
                  end else begin
                     wdog_in[ch] = wdec;
                  end
               end
            end
         end
         ACT_SET: begin
            if (chan_ok && lock_ff[s1_channel_ff] == '0
                && !(s1_channel_ff == CH_HEAT && cool_on)
                && !(s1_channel_ff == CH_COOL && heat_on)) begin
               relay_in[s1_channel_ff] = 1'b1;
               wdog_in[s1_channel_ff]  = timeout_ff;
               out_acc_in              = 1'b1;
            end
         end
         ACT_CLEAR: begin
            if (chan_ok && lock_ff[s1_channel_ff] == '0 && relay_ff[s1_channel_ff]) begin
               relay_in[s1_channel_ff] = 1'b0;
               wdog_in[s1_channel_ff]  = '0;
               lock_in[s1_channel_ff]  = (s1_channel_ff == CH_FAN) ? fan_lockout_ff
                                                                   : lockout_ff;
               out_acc_in              = 1'b1;
            end
         end
         default: begin
            // query leaves state alone
         end
      endcase
      if (!chan_ok) begin
         out_status_in = ST_OFF;
      end else if (lock_in[s1_channel_ff] != '0) begin
         out_status_in = ST_LOCKED;
      end else if (relay_in[s1_channel_ff]) begin
         out_status_in = ST_ON;
      end else begin
         out_status_in = ST_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RST;
         lockout_ff     <= LOCKOUT_RST;
         fan_lockout_ff <= FAN_LOCKOUT_RST;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         relay_ff       <= '0;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            wdog_ff[ch] <= '0;
            lock_ff[ch] <= (ch == 0) ? FAN_LOCKOUT_RST : LOCKOUT_RST;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIMEOUT:     timeout_ff     <= csr_wdata[7:0];
               REG_LOCKOUT:     lockout_ff     <= csr_wdata;
               REG_FAN_LOCKOUT: fan_lockout_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            relay_ff     <= relay_in;
            wdog_ff      <= wdog_in;
            lock_ff      <= lock_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff  <= action_type'(req_action);
         s1_channel_ff <= req_channel;
      end
      if (advance) begin
         out_relay_ff  <= relay_in;
         out_status_ff <= out_status_in;
         out_acc_ff    <= out_acc_in;
      end
   end

   // heat and cool are never driven together
   assert property (@(posedge clock) disable iff (reset)
      !(relay_ff[CH_HEAT] && relay_ff[CH_COOL]))
      else $error("heat and cool both on");

   // a relay that is on has no lockout running
   assert property (@(posedge clock) disable iff (reset)
      (!relay_ff[0] || lock_ff[0] == '0) && (!relay_ff[1] || lock_ff[1] == '0)
      && (!relay_ff[2] || lock_ff[2] == '0))
      else $error("relay on while locked");

   // an item leaving the input stage shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result lost");

   // accepted only ever set by a set or clear item
   assert property (@(posedge clock) disable iff (reset)
      advance && (s1_action_ff == ACT_TICK || s1_action_ff == ACT_QUERY) |=> !rsp_accepted)
      else $error("tick or query marked accepted");

endmodule

@@ tb/sv/tb.sv @@
// testbench for the relay lockout controller: directed and random request items with a checker
module tb;
   import rflc_pkg::*;

   localparam logic [1:0] CH_NONE    = 2'd3;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [2:0] relay_bits;
      status_type chan_status;
      logic       accepted;
   } relay_report;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [1:0]  req_channel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_relay_bits;
   logic [1:0]  rsp_channel_status;
   logic        rsp_accepted;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // predicted controller state and register copies
   logic [2:0] relay_q;
   wdog_type   wdog_q [NUM_CH];
   lock_type   lock_q [NUM_CH];
   wdog_type   cfg_timeout;
   lock_type   cfg_lockout;
   lock_type   cfg_fan_lockout;

   relay_report pending_reports[$];
   bit jitter = 1'b1;
   int errors = 0;
   int items_sent = 0;
   int reports_checked = 0;
   int reg_writes = 0;

   relay_failsafe_lockout_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_relay_bits     (rsp_relay_bits),
      .rsp_channel_status (rsp_channel_status),
      .rsp_accepted       (rsp_accepted),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic status_type relay_status(int c);
      if (lock_q[c] != '0) return ST_LOCKED;
      return relay_q[c] ? ST_ON : ST_OFF;
   endfunction

   function automatic bit grant_set(int c);
      if (relay_status(c) == ST_LOCKED) return 1'b0;
      if (c == CH_HEAT && relay_status(CH_COOL) == ST_ON) return 1'b0;
      if (c == CH_COOL && relay_status(CH_HEAT) == ST_ON) return 1'b0;
      relay_q[c] = 1'b1;
      wdog_q[c]  = cfg_timeout;
      return 1'b1;
   endfunction

   function automatic bit release_relay(int c);
      if (relay_status(c) != ST_ON) return 1'b0;
      wdog_q[c]  = '0;
      lock_q[c]  = (c == CH_FAN) ? cfg_fan_lockout : cfg_lockout;
      relay_q[c] = 1'b0;
      return 1'b1;
   endfunction

   function automatic void second_tick();
      for (int c = 0; c < NUM_CH; c++) begin
         if (lock_q[c] != '0) begin
            lock_q[c] = lock_q[c] - 1'b1;
         end else if (relay_status(c) == ST_ON) begin
            if (wdog_q[c] != '0) wdog_q[c] = wdog_q[c] - 1'b1;
            if (wdog_q[c] == '0) void'(release_relay(c));
         end
      end
   endfunction

   function automatic void apply_request(action_type act, logic [1:0] ch);
      relay_report r;
      bit ok;
      ok = 1'b0;
      case (act)
         ACT_TICK: begin
            second_tick();
         end
         ACT_SET: begin
            if (ch < NUM_CH) ok = grant_set(int'(ch));
         end
         ACT_CLEAR: begin
            if (ch < NUM_CH) ok = release_relay(int'(ch));
         end
         default: begin
         end
      endcase
      r.relay_bits  = relay_q;
      r.chan_status = (ch < NUM_CH) ? relay_status(int'(ch)) : ST_OFF;
      r.accepted    = ok;
      pending_reports.push_back(r);
   endfunction

   // ---------------- result side ----------------

   always @(negedge clock) begin
      rsp_stall = jitter && ($urandom_range(99) < 32);
   end

   always @(posedge clock) begin : check_reports
      relay_report want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_relay_bits !== want.relay_bits) begin
               $error("relay_bits: expected %0d, got %0d", want.relay_bits, rsp_relay_bits);
               errors++;
            end
            if (rsp_channel_status !== want.chan_status) begin
               $error("channel_status: expected %0d, got %0d",
                      want.chan_status, rsp_channel_status);
               errors++;
            end
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_accepted);
               errors++;
            end
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_item(input action_type act, input logic [1:0] ch);
      @(negedge clock);
      while (jitter && $urandom_range(99) < 32) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_action  = act;
      req_channel = ch;
      do @(posedge clock); while (req_stall);
      apply_request(act, ch);
      items_sent++;
   endtask

   // hold requests back until every expected result has come out
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TIMEOUT:     cfg_timeout     = data[7:0];
         REG_LOCKOUT:     cfg_lockout     = data;
         REG_FAN_LOCKOUT: cfg_fan_lockout = data;
         default: begin
         end
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [15:0] t, input logic [15:0] l, input logic [15:0] f);
      write_reg(REG_TIMEOUT, t);
      write_reg(REG_LOCKOUT, l);
      write_reg(REG_FAN_LOCKOUT, f);
   endtask

   task automatic random_item();
      action_type act;
      logic [1:0] ch;
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)      act = ACT_TICK;
      else if (pick < 60) act = ACT_SET;
      else if (pick < 85) act = ACT_CLEAR;
      else                act = ACT_QUERY;
      ch = ($urandom_range(15) == 0) ? CH_NONE : 2'($urandom_range(2));
      send_item(act, ch);
   endtask

   // ---------------- tests ----------------

   // all channels start locked; ticks count the power-up lockouts away
   task automatic test_power_up_lockout();
      send_item(ACT_QUERY, CH_FAN);
      send_item(ACT_QUERY, CH_HEAT);
      send_item(ACT_QUERY, CH_COOL);
      send_item(ACT_QUERY, CH_NONE);
      send_item(ACT_SET, CH_HEAT);
      send_item(ACT_CLEAR, CH_FAN);
      for (int i = 0; i < 305; i++) begin
         if (i % 50 == 0) send_item(ACT_QUERY, 2'($urandom_range(2)));
         send_item(ACT_TICK, 2'($urandom_range(3)));
      end
      send_item(ACT_QUERY, CH_HEAT);
      drain();
   endtask

   task automatic test_interlock();
      set_config(16'd10, 16'd3, 16'd1);
      send_item(ACT_SET, CH_FAN);
      send_item(ACT_SET, CH_HEAT);
      send_item(ACT_SET, CH_COOL);      // refused, heat on
      send_item(ACT_SET, CH_HEAT);      // already on: watchdog reload
      send_item(ACT_QUERY, CH_HEAT);
      send_item(ACT_CLEAR, CH_HEAT);
      send_item(ACT_SET, CH_HEAT);      // locked
      send_item(ACT_SET, CH_COOL);
      send_item(ACT_SET, CH_HEAT);
      send_item(ACT_CLEAR, CH_COOL);
      send_item(ACT_CLEAR, CH_COOL);    // clear of a locked relay is ignored
      send_item(ACT_CLEAR, CH_HEAT);
      repeat (4) send_item(ACT_TICK, CH_FAN);
      send_item(ACT_QUERY, CH_HEAT);
      send_item(ACT_QUERY, CH_COOL);
      send_item(ACT_CLEAR, CH_FAN);
      send_item(ACT_CLEAR, CH_HEAT);    // off, ignored
      drain();
   endtask

   task automatic test_watchdog_expiry();
      write_reg(REG_TIMEOUT, 16'd2);
      repeat (2) send_item(ACT_TICK, CH_COOL);
      send_item(ACT_SET, CH_FAN);
      send_item(ACT_SET, CH_HEAT);
      send_item(ACT_TICK, CH_FAN);
      send_item(ACT_QUERY, CH_FAN);
      send_item(ACT_TICK, CH_HEAT);     // both watchdogs run out
      send_item(ACT_QUERY, CH_HEAT);
      repeat (4) send_item(ACT_TICK, CH_FAN);
      // zero timeout: the next tick switches the relay off
      write_reg(REG_TIMEOUT, 16'd0);
      send_item(ACT_SET, CH_COOL);
      send_item(ACT_TICK, CH_COOL);
      send_item(ACT_QUERY, CH_COOL);
      drain();
   endtask

   task automatic test_unused_channel();
      send_item(ACT_SET, CH_NONE);
      send_item(ACT_CLEAR, CH_NONE);
      send_item(ACT_QUERY, CH_NONE);
      send_item(ACT_TICK, CH_NONE);
      write_reg(REG_UNUSED, 16'hFFFF);
      send_item(ACT_QUERY, CH_FAN);
      drain();
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < 8; ph++) begin
         int n;
         n = 60;
         jitter = (ph != 0);
         if (ph == 1) begin
            set_config(16'd0, 16'd0, 16'd0);
         end else if (ph == 7) begin
            // maximum settings last: the long lockouts never run out
            set_config(16'd255, 16'hFFFF, 16'hFFFF);
            n = 30;
         end else begin
            // upper byte of the timeout write is junk and must be dropped
            set_config({8'($urandom), 8'($urandom_range(6))},
                       16'($urandom_range(8)), 16'($urandom_range(8)));
            if (ph == 2) write_reg(REG_UNUSED, 16'($urandom));
         end
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(59) == 0) drain();
            random_item();
         end
         drain();
      end
      jitter = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_action  = ACT_TICK;
      req_channel = CH_FAN;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = REG_TIMEOUT;
      csr_wdata   = '0;
      relay_q     = '0;
      for (int c = 0; c < NUM_CH; c++) wdog_q[c] = '0;
      lock_q[CH_FAN]  = FAN_LOCKOUT_RST;
      lock_q[CH_HEAT] = LOCKOUT_RST;
      lock_q[CH_COOL] = LOCKOUT_RST;
      cfg_timeout     = TIMEOUT_RST;
      cfg_lockout     = LOCKOUT_RST;
      cfg_fan_lockout = FAN_LOCKOUT_RST;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_up_lockout();
      test_interlock();
      test_watchdog_expiry();
      test_unused_channel();
      test_random_traffic();

      drain();
      repeat (10) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d result items never arrived", pending_reports.size());
         errors++;
      end
      $display("run covered %0d request items, %0d results checked, %0d register writes",
               items_sent, reports_checked, reg_writes);
      $display("ticks, sets, clears and queries on all channel codes, interlock and expiry");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rflc_pkg.sv
hw/rtl/relay_failsafe_lockout_controller.sv
tb/sv/tb.sv
